// ===== rtl/core/sfgb_pkg.sv =====
`timescale 1ns / 1ps

package sfgb_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR    = 3'd5;

    // Field widths.
    localparam int CODE_W  = 8;
    localparam int COORD_W = 12;
    localparam int SCALE_W = 4;
    localparam int COLOR_W = 16;
    localparam int POS_W   = 11;
    localparam int CNT_W   = 4;
    localparam int ADDR_W  = 22;
    localparam int PEN_W   = 13;
    localparam int CELL_W  = 14;

    localparam logic [COORD_W-1:0] DIM_MAX = 12'd2048;
    localparam logic [COORD_W-1:0] PEN_MAX = 12'd4095;

    localparam int GLYPH_COUNT = 14;
    localparam int GLYPH_IDX_W = 4;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_BLANK = 4'd13;

    // Column-major glyphs, bit 0 of each column byte is the top row.
    localparam logic [7:0] GLYPH_ROM [0:GLYPH_COUNT-1][0:7] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00, 8'h00, 8'h00},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00, 8'h00, 8'h00},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h00, 8'h00},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00, 8'h00, 8'h00},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00, 8'h00},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C, 8'h00, 8'h00, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } sfgb_state_t;

    typedef struct packed {
        logic load;   // latch a new character and set up the cell walk
        logic issue;  // push the current cell into the datapath pipeline
    } sfgb_cmd_t;

    typedef struct packed {
        logic slot_free;     // the first pipeline stage can take a cell
        logic at_last_cell;  // the current cell is the final one of the glyph
    } sfgb_stat_t;

    // Map a character code to its glyph; unknown codes map to the blank glyph.
    function automatic logic [GLYPH_IDX_W-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
        logic [GLYPH_IDX_W-1:0] idx;
        idx = GLYPH_BLANK;
        case (code)
            8'h30:   idx = 4'd0;
            8'h31:   idx = 4'd1;
            8'h32:   idx = 4'd2;
            8'h33:   idx = 4'd3;
            8'h34:   idx = 4'd4;
            8'h35:   idx = 4'd5;
            8'h36:   idx = 4'd6;
            8'h37:   idx = 4'd7;
            8'h38:   idx = 4'd8;
            8'h39:   idx = 4'd9;
            8'h2E:   idx = 4'd10;
            8'h76:   idx = 4'd11;
            8'h2D:   idx = 4'd12;
            default: idx = GLYPH_BLANK;
        endcase
        return idx;
    endfunction

    function automatic logic [7:0] glyph_column(input logic [GLYPH_IDX_W-1:0] idx,
                                                input logic [2:0] col);
        logic [7:0] bits;
        bits = 8'h00;
        if (idx < GLYPH_IDX_W'(GLYPH_COUNT))
        begin
            bits = GLYPH_ROM[idx][col];
        end
        return bits;
    endfunction

endpackage

// ===== rtl/core/sfgb_ctrl.sv =====
`timescale 1ns / 1ps

module sfgb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sfgb_pkg::sfgb_stat_t  stat,
    output sfgb_pkg::sfgb_cmd_t   cmd
);
    import sfgb_pkg::*;

    sfgb_state_t state_reg;
    sfgb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.slot_free)
                begin
                    cmd.issue = 1'b1;
                    if (stat.at_last_cell)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_issue_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> stat.slot_free)
        else $error("cell issued while the first stage was occupied");

    a_last_cell_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && stat.at_last_cell) |=> in_ready)
        else $error("input not reopened after the final cell");

    a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("input open while a character is being walked");
`endif

endmodule

// ===== rtl/core/sfgb_dp.sv =====
`timescale 1ns / 1ps

module sfgb_dp #(
    parameter int GLYPH_COLUMNS = 5,
    parameter int GLYPH_ROWS    = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_enable,
    input  logic [sfgb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfgb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [sfgb_pkg::CODE_W-1:0]           char_code,
    input  logic                                  first,
    input  sfgb_pkg::sfgb_cmd_t                   cmd,
    output sfgb_pkg::sfgb_stat_t                  stat,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  write_enable,
    output logic [sfgb_pkg::POS_W-1:0]            x_start,
    output logic [sfgb_pkg::POS_W-1:0]            y_start,
    output logic [sfgb_pkg::CNT_W-1:0]            x_count,
    output logic [sfgb_pkg::CNT_W-1:0]            y_count,
    output logic [sfgb_pkg::ADDR_W-1:0]           pixel_address,
    output logic [sfgb_pkg::COLOR_W-1:0]          pixel_value,
    output logic                                  last
);
    import sfgb_pkg::*;

    localparam int COL_W   = $clog2(GLYPH_COLUMNS);
    localparam int ROW_W   = $clog2(GLYPH_ROWS);
    localparam int ADVANCE = GLYPH_COLUMNS + 1;
    localparam int STEP_W  = $clog2(ADVANCE * 15 + 1);
    localparam int MUL_W   = POS_W + COORD_W;

    // Clip [start, start+len) to [0, bound).
    typedef struct packed {
        logic             vis;
        logic [POS_W-1:0] lo;
        logic [CNT_W-1:0] cnt;
    } clip_t;

    function automatic clip_t clip_span(input logic signed [CELL_W-1:0] start,
                                        input logic [SCALE_W-1:0] len,
                                        input logic [COORD_W-1:0] bound);
        logic signed [CELL_W:0] a;
        logic signed [CELL_W:0] e;
        logic signed [CELL_W:0] bnd;
        logic signed [CELL_W:0] diff;
        clip_t r;
        a    = (start < 0) ? '0 : (CELL_W+1)'(start);
        e    = (CELL_W+1)'(start) + $signed({{(CELL_W+1-SCALE_W){1'b0}}, len});
        bnd  = $signed({{(CELL_W+1-COORD_W){1'b0}}, bound});
        if (e > bnd)
        begin
            e = bnd;
        end
        diff  = e - a;
        r.vis = e > a;
        r.lo  = a[POS_W-1:0];
        r.cnt = diff[CNT_W-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic [COORD_W-1:0]        fb_width_reg;
    logic [COORD_W-1:0]        fb_height_reg;
    logic [COLOR_W-1:0]        colour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            scale_reg     <= SCALE_W'(1);
            fb_width_reg  <= COORD_W'(320);
            fb_height_reg <= COORD_W'(240);
            colour_reg    <= '1;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_data[COORD_W-1:0];
                REG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_FB_WIDTH:  fb_width_reg  <= cfg_data[COORD_W-1:0];
                REG_FB_HEIGHT: fb_height_reg <= cfg_data[COORD_W-1:0];
                REG_COLOUR:    colour_reg    <= cfg_data[COLOR_W-1:0];
                default:       ;
            endcase
        end
    end

    logic [SCALE_W-1:0] s_eff;
    logic [COORD_W-1:0] w_eff;
    logic [COORD_W-1:0] h_eff;

    assign s_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    assign w_eff = (fb_width_reg > DIM_MAX) ? DIM_MAX : fb_width_reg;
    assign h_eff = (fb_height_reg > DIM_MAX) ? DIM_MAX : fb_height_reg;

    // Character walk state.
    logic signed [PEN_W-1:0]  pen_reg;
    logic signed [PEN_W-1:0]  pen_next;
    logic [GLYPH_IDX_W-1:0]   glyph_reg;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic signed [CELL_W-1:0] cell_x_reg;
    logic signed [CELL_W-1:0] cell_y_reg;

    logic [STEP_W-1:0]        pen_step;
    logic signed [CELL_W-1:0] pen_sum;
    logic                     row_end;
    logic                     at_last_cell;

    assign row_end      = row_reg == ROW_W'(GLYPH_ROWS - 1);
    assign at_last_cell = row_end && (col_reg == COL_W'(GLYPH_COLUMNS - 1));

    assign pen_step = STEP_W'(ADVANCE) * STEP_W'(s_eff);
    assign pen_sum  = CELL_W'(pen_reg) + $signed({{(CELL_W-STEP_W){1'b0}}, pen_step});

    always_comb
    begin
        pen_next = pen_reg;
        if (cmd.load && first)
        begin
            pen_next = PEN_W'(origin_x_reg);
        end
        else if (cmd.issue && at_last_cell)
        begin
            if (pen_sum > $signed({{(CELL_W-COORD_W){1'b0}}, PEN_MAX}))
            begin
                pen_next = $signed({1'b0, PEN_MAX});
            end
            else
            begin
                pen_next = pen_sum[PEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
        end
        else
        begin
            pen_reg <= pen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg  <= glyph_lookup(char_code);
            col_reg    <= '0;
            row_reg    <= '0;
            cell_x_reg <= CELL_W'(pen_next);
            cell_y_reg <= CELL_W'(origin_y_reg);
        end
        else if (cmd.issue)
        begin
            if (row_end)
            begin
                row_reg    <= '0;
                col_reg    <= col_reg + COL_W'(1);
                cell_y_reg <= CELL_W'(origin_y_reg);
                cell_x_reg <= cell_x_reg + $signed({{(CELL_W-SCALE_W){1'b0}}, s_eff});
            end
            else
            begin
                row_reg    <= row_reg + ROW_W'(1);
                cell_y_reg <= cell_y_reg + $signed({{(CELL_W-SCALE_W){1'b0}}, s_eff});
            end
        end
    end

    // Stage A: lit test and clipping.
    logic [7:0] col_bits;
    logic       lit;
    clip_t      clip_x;
    clip_t      clip_y;
    logic       cell_we;

    assign col_bits = glyph_column(glyph_reg, 3'(col_reg));
    assign lit      = col_bits[3'(row_reg)];
    assign clip_x   = clip_span(cell_x_reg, s_eff, w_eff);
    assign clip_y   = clip_span(cell_y_reg, s_eff, h_eff);
    assign cell_we  = lit && clip_x.vis && clip_y.vis;

    logic             a_valid_reg;
    logic             a_we_reg;
    logic [POS_W-1:0] a_xs_reg;
    logic [POS_W-1:0] a_ys_reg;
    logic [CNT_W-1:0] a_xc_reg;
    logic [CNT_W-1:0] a_yc_reg;
    logic             a_last_reg;

    logic out_free;
    logic a_move;

    assign out_free       = !out_valid || out_ready;
    assign a_move         = a_valid_reg && out_free;
    assign stat.slot_free    = !a_valid_reg || a_move;
    assign stat.at_last_cell = at_last_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_move)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            a_we_reg   <= cell_we;
            a_xs_reg   <= cell_we ? clip_x.lo  : '0;
            a_ys_reg   <= cell_we ? clip_y.lo  : '0;
            a_xc_reg   <= cell_we ? clip_x.cnt : '0;
            a_yc_reg   <= cell_we ? clip_y.cnt : '0;
            a_last_reg <= at_last_cell;
        end
    end

    // Output stage: address multiply and result register.
    logic [MUL_W-1:0] addr_full;

    assign addr_full = MUL_W'(a_ys_reg) * MUL_W'(w_eff) + MUL_W'(a_xs_reg);

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic               we_reg;
    logic [POS_W-1:0]   xs_reg;
    logic [POS_W-1:0]   ys_reg;
    logic [CNT_W-1:0]   xc_reg;
    logic [CNT_W-1:0]   yc_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] value_reg;
    logic               last_reg;

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            we_reg    <= a_we_reg;
            xs_reg    <= a_xs_reg;
            ys_reg    <= a_ys_reg;
            xc_reg    <= a_xc_reg;
            yc_reg    <= a_yc_reg;
            addr_reg  <= addr_full[ADDR_W-1:0];
            value_reg <= a_we_reg ? colour_reg : '0;
            last_reg  <= a_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_enable  = we_reg;
    assign x_start       = xs_reg;
    assign y_start       = ys_reg;
    assign x_count       = xc_reg;
    assign y_count       = yc_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_move) |=> (a_valid_reg && $stable(a_last_reg) && $stable(a_xs_reg)))
        else $error("stalled cell lost in the first stage");

    a_write_has_area: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && we_reg) |-> (xc_reg != '0 && yc_reg != '0))
        else $error("write flagged on an empty block");

    a_idle_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !we_reg) |-> (addr_reg == '0 && value_reg == '0))
        else $error("unwritten cell carries nonzero address or value");
`endif

endmodule

// ===== rtl/core/scaled_font_glyph_blitter_top.sv =====
`timescale 1ns / 1ps

// Scaled 5x7 character generator. Each input transaction carries one character
// code; the block walks the glyph cell by cell, column by column with rows top to
// bottom, and returns GLYPH_COLUMNS*GLYPH_ROWS output transactions per character
// (35 with the default glyph), each describing one scale-by-scale fill block that
// has already been clipped to the framebuffer, with its start address
// y_start*width+x_start. Unknown codes draw blank but still produce every cell and
// still move the pen. A character is loaded on its input transaction, and then the
// controller hands one cell per cycle, whenever the first pipeline stage has room,
// to a two-stage pipeline (clipping, then the address multiply and result register),
// so a stall on out_ready holds the cell walk.
// The next character is accepted as soon as the last cell of the current one has
// entered the pipeline, while earlier results may still be waiting on out_ready.
// Configuration registers are written through cfg_write_enable, cfg_index and
// cfg_data and should only be changed while no character is in flight.

module scaled_font_glyph_blitter_top #(
    parameter int GLYPH_COLUMNS = 5,
    parameter int GLYPH_ROWS    = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_enable,
    input  logic [sfgb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfgb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sfgb_pkg::CODE_W-1:0]           char_code,
    input  logic                                  first,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  write_enable,
    output logic [sfgb_pkg::POS_W-1:0]            x_start,
    output logic [sfgb_pkg::POS_W-1:0]            y_start,
    output logic [sfgb_pkg::CNT_W-1:0]            x_count,
    output logic [sfgb_pkg::CNT_W-1:0]            y_count,
    output logic [sfgb_pkg::ADDR_W-1:0]           pixel_address,
    output logic [sfgb_pkg::COLOR_W-1:0]          pixel_value,
    output logic                                  last
);
    import sfgb_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    sfgb_cmd_t  cmd;
    sfgb_stat_t stat;

    // The controller sequences one character at a time: it loads the character
    // on an input transaction, then issues one cell per cycle whenever the
    // datapath pipeline has room.
    sfgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the pen, the glyph ROM
    // lookup, the cell clipping and the output register.
    sfgb_dp #(
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .GLYPH_ROWS    (GLYPH_ROWS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .char_code        (char_code),
        .first            (first),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .write_enable     (write_enable),
        .x_start          (x_start),
        .y_start          (y_start),
        .x_count          (x_count),
        .y_count          (y_count),
        .pixel_address    (pixel_address),
        .pixel_value      (pixel_value),
        .last             (last)
    );

endmodule
